### hdl/okts_pkg.sv
// ----------------------------------------------------------------------------
// okts_pkg: shared types and constants of the ordered key table
// Capacity, index widths, command and status codes, and transaction structs.
// ----------------------------------------------------------------------------
package okts_pkg;

   localparam int CAPACITY = 256;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_FIND   = 2'd2;
   localparam logic [1:0] CMD_SUCC   = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_DUP    = 2'd1;
   localparam logic [1:0] ST_ABSENT = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] lookup_key;
      logic [31:0] record_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] record_out;
   } rsp_type;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] record;
   } entry_type;

   typedef struct packed {
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
   } mem_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [CNT_W-1:0] count;
   } seq_stat_type;

endpackage

### hdl/okts_mem.sv
// ----------------------------------------------------------------------------
// okts_mem: entry storage
// One write port and one read port, read data registered. Contents are
// undefined until written.
// ----------------------------------------------------------------------------
module okts_mem (
   input  logic                 clock,
   input  okts_pkg::mem_req_type mem_req,
   output okts_pkg::entry_type   rd_data
);

   okts_pkg::entry_type mem_ff [okts_pkg::CAPACITY];
   okts_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_ff <= mem_ff[mem_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/okts_seq.sv
// ----------------------------------------------------------------------------
// okts_seq: command sequencer
// Binary search with one shared key comparator, then an entry-by-entry
// shift through the memory for insert and delete.
// ----------------------------------------------------------------------------
module okts_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  okts_pkg::req_type     req_data,
   input  okts_pkg::entry_type   rd_data,
   output okts_pkg::mem_req_type mem_req,
   output okts_pkg::seq_stat_type stat,
   output okts_pkg::rsp_type     result
);

   localparam int CW = okts_pkg::CNT_W;
   localparam int IW = okts_pkg::IDX_W;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SRCH = 4'd1;
   localparam logic [3:0] S_SCMP = 4'd2;
   localparam logic [3:0] S_HIT  = 4'd3;
   localparam logic [3:0] S_DEC  = 4'd4;
   localparam logic [3:0] S_WRAP = 4'd5;
   localparam logic [3:0] S_SHR  = 4'd6;
   localparam logic [3:0] S_SHW  = 4'd7;
   localparam logic [3:0] S_DONE = 4'd8;

   localparam logic [CW-1:0] FULL_COUNT = CW'(okts_pkg::CAPACITY);
   localparam logic [CW-1:0] ONE        = CW'(1);

   logic [3:0]        state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     lo_ff, lo_in;
   logic [CW-1:0]     hi_ff, hi_in;
   logic [CW-1:0]     mid_ff, mid_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic              hit_ff, hit_in;
   logic [31:0]       found_ff, found_in;
   okts_pkg::req_type cur_ff, cur_in;
   okts_pkg::rsp_type res_ff, res_in;

   logic [CW-1:0] mid;
   logic [CW-1:0] idx_dec;
   logic [CW-1:0] idx_inc;
   logic          key_lt;
   logic          key_eq;

   // the one comparator: stored key read back against the key asked for
   assign key_lt  = rd_data.key < cur_ff.lookup_key;
   assign key_eq  = rd_data.key == cur_ff.lookup_key;
   assign mid     = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign idx_dec = idx_ff - ONE;
   assign idx_inc = idx_ff + ONE;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      idx_in   = idx_ff;
      hit_in   = hit_ff;
      found_in = found_ff;
      cur_in   = cur_ff;
      res_in   = res_ff;
      mem_req  = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cur_in   = req_data;
               lo_in    = '0;
               hi_in    = count_ff;
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (lo_ff < hi_ff) begin
               mem_req.rd_addr = mid[IW-1:0];
               mid_in          = mid;
               state_in        = S_SCMP;
            end else if (lo_ff < count_ff) begin
               mem_req.rd_addr = lo_ff[IW-1:0];
               state_in        = S_HIT;
            end else begin
               hit_in   = 1'b0;
               state_in = S_DEC;
            end
         end
         S_SCMP: begin
            if (key_lt) begin
               lo_in = mid_ff + ONE;
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_SRCH;
         end
         S_HIT: begin
            hit_in   = key_eq;
            found_in = rd_data.record;
            state_in = S_DEC;
         end
         S_DEC: begin
            res_in.record_out = '0;
            res_in.status     = okts_pkg::ST_OK;
            state_in          = S_DONE;
            unique case (cur_ff.cmd)
               okts_pkg::CMD_INSERT: begin
                  if (hit_ff) begin
                     res_in.status = okts_pkg::ST_DUP;
                  end else if (count_ff == FULL_COUNT) begin
                     res_in.status = okts_pkg::ST_FULL;
                  end else begin
                     idx_in   = count_ff;
                     state_in = S_SHR;
                  end
               end
               okts_pkg::CMD_DELETE: begin
                  if (!hit_ff) begin
                     res_in.status = okts_pkg::ST_ABSENT;
                  end else begin
                     idx_in   = lo_ff;
                     state_in = S_SHR;
                  end
               end
               okts_pkg::CMD_FIND: begin
                  if (hit_ff) begin
                     res_in.record_out = found_ff;
                  end else begin
                     res_in.status = okts_pkg::ST_ABSENT;
                  end
               end
               okts_pkg::CMD_SUCC: begin
                  if (count_ff == '0) begin
                     res_in.status = okts_pkg::ST_ABSENT;
                  end else if (lo_ff < count_ff) begin
                     res_in.record_out = found_ff;
                  end else begin
                     // past the largest key: wrap to the first entry
                     mem_req.rd_addr = '0;
                     state_in        = S_WRAP;
                  end
               end
               default: ;
            endcase
         end
         S_WRAP: begin
            res_in.record_out = rd_data.record;
            state_in          = S_DONE;
         end
         S_SHR: begin
            if (cur_ff.cmd == okts_pkg::CMD_INSERT) begin
               if (idx_ff > lo_ff) begin
                  mem_req.rd_addr = idx_dec[IW-1:0];
                  state_in        = S_SHW;
               end else begin
                  mem_req.wr_en          = 1'b1;
                  mem_req.wr_addr        = lo_ff[IW-1:0];
                  mem_req.wr_data.key    = cur_ff.lookup_key;
                  mem_req.wr_data.record = cur_ff.record_in;
                  count_in               = count_ff + ONE;
                  state_in               = S_DONE;
               end
            end else begin
               if (idx_inc < count_ff) begin
                  mem_req.rd_addr = idx_inc[IW-1:0];
                  state_in        = S_SHW;
               end else begin
                  count_in = count_ff - ONE;
                  state_in = S_DONE;
               end
            end
         end
         S_SHW: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = idx_ff[IW-1:0];
            mem_req.wr_data = rd_data;
            idx_in          = (cur_ff.cmd == okts_pkg::CMD_INSERT) ? idx_dec : idx_inc;
            state_in        = S_SHR;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      idx_ff   <= idx_in;
      hit_ff   <= hit_in;
      found_ff <= found_in;
      cur_ff   <= cur_in;
      res_ff   <= res_in;
   end

   assign stat.busy  = state_ff != S_IDLE;
   assign stat.done  = state_ff == S_DONE;
   assign stat.count = count_ff;
   assign result     = res_ff;

endmodule

### hdl/ordered_key_table_with_successor.sv
// ----------------------------------------------------------------------------
// ordered_key_table_with_successor: sorted key table with ceiling lookup
// Ordered map of unique 32-bit keys to 32-bit record handles.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction (req_data: cmd, lookup_key, record_in) is taken on
//   a clock edge with start high and busy low. busy stays high while the
//   command runs. Exactly one response (rsp_data: status, record_out) shows
//   on the rsp_ ports for one cycle, flagged by rsp_strobe; the receiver
//   must take it then, there is no back-pressure. busy is low again in the
//   strobe cycle, so the next command may start there.
//   Operation: the binary search reads the entry memory once per step, then
//   compares the stored key read back against the key asked for.
//   Insert and delete then move entries one at a time, each read and then
//   written back through the memory's separate read and write ports.
//   Reset empties the table at once (count cleared); entry memory is not
//   cleared and needs no sweep.
// ----------------------------------------------------------------------------
module ordered_key_table_with_successor (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  okts_pkg::req_type req_data,
   output logic              rsp_strobe,
   output okts_pkg::rsp_type rsp_data
);

   okts_pkg::mem_req_type  mem_req;
   okts_pkg::entry_type    rd_data;
   okts_pkg::seq_stat_type stat;
   okts_pkg::rsp_type      result;

   logic              rsp_strobe_ff;
   okts_pkg::rsp_type rsp_data_ff;

   okts_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .rd_data  (rd_data),
      .mem_req  (mem_req),
      .stat     (stat),
      .result   (result)
   );

   okts_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= stat.done;
      end
      rsp_data_ff <= result;
   end

   assign busy       = stat.busy;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted command did not raise busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response while a command is still running");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two responses in a row");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      stat.count <= okts_pkg::CNT_W'(okts_pkg::CAPACITY))
      else $error("entry count beyond capacity");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.status == okts_pkg::ST_FULL)
      |-> stat.count == okts_pkg::CNT_W'(okts_pkg::CAPACITY))
      else $error("table full reported below capacity");

endmodule
